[rtl/ir_pulse_distance_decoder_defines.svh]
// ---------------------------------------------------------------------------
// IR pulse-distance decoder assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_DECODER_DEFINES_SVH
`define IR_PULSE_DISTANCE_DECODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define IRPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ir_pd assertion failed");
// next-cycle implication
`define IRPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ir_pd assertion failed");
`else
`define IRPD_ASSERT_NOW(lbl, ante, cons)
`define IRPD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/ir_pd_pkg.sv]
// ---------------------------------------------------------------------------
// IR pulse-distance decoder package
// Shared types, register indexes and the seven-segment lookup.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ir_pd_pkg;

  // decoder phase, encoding matches the decode_phase output
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_START_TIMEOUT = 3'd0,
    CFG_START_MIN     = 3'd1,
    CFG_BIT_TIMEOUT   = 3'd2,
    CFG_ONE_THRESHOLD = 3'd3,
    CFG_SLOW_PERIOD   = 3'd4,
    CFG_HOLDOFF       = 3'd5,
    CFG_DEBOUNCE      = 3'd6,
    CFG_UNUSED        = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CodeW    = 32;

  // reset values of the configuration registers
  localparam logic [15:0] RstStartTimeout = 16'd23603;
  localparam logic [15:0] RstStartMin     = 16'h0733;
  localparam logic [15:0] RstBitTimeout   = 16'd7871;
  localparam logic [15:0] RstOneThreshold = 16'h05DC;
  localparam logic [15:0] RstSlowPeriod   = 16'd50000;
  localparam logic [2:0]  RstHoldoff      = 3'd5;
  localparam logic [2:0]  RstDebounce     = 3'd5;

  typedef struct packed {
    logic [15:0] start_timeout;
    logic [15:0] start_min;
    logic [15:0] bit_timeout;
    logic [15:0] one_threshold;
    logic [15:0] slow_period;
    logic [2:0]  holdoff;
    logic [2:0]  debounce;
  } cfg_t;

  // next-state view of the frame decoder handed to the output stage
  typedef struct packed {
    phase_e           phase;
    logic             valid;
    logic [CodeW-1:0] code;
    logic             slow_tick;
  } frame_res_t;

  // active-low seven-segment patterns, hex digits 0..F
  function automatic logic [7:0] seg_lut(input logic [3:0] nib);
    logic [7:0] pat;
    case (nib)
      4'h0: pat = 8'hC0;
      4'h1: pat = 8'hF3;
      4'h2: pat = 8'hA4;
      4'h3: pat = 8'hA1;
      4'h4: pat = 8'h93;
      4'h5: pat = 8'h89;
      4'h6: pat = 8'h88;
      4'h7: pat = 8'hE3;
      4'h8: pat = 8'h80;
      4'h9: pat = 8'h81;
      4'hA: pat = 8'h82;
      4'hB: pat = 8'h98;
      4'hC: pat = 8'hCC;
      4'hD: pat = 8'hB0;
      4'hE: pat = 8'h8C;
      4'hF: pat = 8'h8E;
      default: pat = 8'hFF;
    endcase
    return pat;
  endfunction

endpackage

[rtl/ir_pd_cfg_regs.sv]
// ---------------------------------------------------------------------------
// IR pulse-distance decoder configuration registers
// Write-only register file, one register per used index, no read-back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ir_pd_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ir_pd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ir_pd_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output ir_pd_pkg::cfg_t                     cfg_o
);
  import ir_pd_pkg::*;

  cfg_t cfg_q, cfg_d;

  // decode the write index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START_TIMEOUT: cfg_d.start_timeout = cfg_wdata_i;
        CFG_START_MIN:     cfg_d.start_min     = cfg_wdata_i;
        CFG_BIT_TIMEOUT:   cfg_d.bit_timeout   = cfg_wdata_i;
        CFG_ONE_THRESHOLD: cfg_d.one_threshold = cfg_wdata_i;
        CFG_SLOW_PERIOD:   cfg_d.slow_period   = cfg_wdata_i;
        CFG_HOLDOFF:       cfg_d.holdoff       = cfg_wdata_i[2:0];
        CFG_DEBOUNCE:      cfg_d.debounce      = cfg_wdata_i[2:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_timeout <= RstStartTimeout;
      cfg_q.start_min     <= RstStartMin;
      cfg_q.bit_timeout   <= RstBitTimeout;
      cfg_q.one_threshold <= RstOneThreshold;
      cfg_q.slow_period   <= RstSlowPeriod;
      cfg_q.holdoff       <= RstHoldoff;
      cfg_q.debounce      <= RstDebounce;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/ir_pd_frame.sv]
// ---------------------------------------------------------------------------
// IR pulse-distance decoder frame engine
// Gap timer, start/data/done sequencing, bit shifter, code latch, hold-off
// and the slow housekeeping prescaler. State advances on step_i only.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ir_pulse_distance_decoder_defines.svh"

module ir_pd_frame #(
  parameter int unsigned CODE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   ir_fall_i,
  input  ir_pd_pkg::cfg_t        cfg_i,
  output ir_pd_pkg::frame_res_t  res_o
);
  import ir_pd_pkg::*;

  phase_e                phase_q, phase_d;
  logic [15:0]           timer_q, timer_d;
  logic                  run_q, run_d;
  logic [CODE_BITS-1:0]  shift_q, shift_d;
  logic [CodeW-1:0]      code_q, code_d;
  logic                  valid_q, valid_d;
  logic                  en_q, en_d;
  logic [2:0]            hold_q, hold_d;
  logic [15:0]           pre_q, pre_d;
  logic                  slow_tick;
  logic [CODE_BITS+CodeW-1:0] shift_ext;

  // low code bits of the shifter, zero-extended when it is narrower
  assign shift_ext = {{CodeW{1'b0}}, shift_q};

  // one tick of frame processing
  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    run_d     = run_q;
    shift_d   = shift_q;
    code_d    = code_q;
    valid_d   = valid_q;
    en_d      = en_q;
    hold_d    = hold_q;
    pre_d     = pre_q;
    slow_tick = 1'b0;

    // gap timer and timeouts
    if (run_q) begin
      if (timer_q != 16'hFFFF) begin
        timer_d = timer_q + 16'd1;
      end
      if (phase_q == PH_START && timer_d >= cfg_i.start_timeout) begin
        phase_d = PH_IDLE;
        run_d   = 1'b0;
      end else if (phase_q == PH_DATA && timer_d >= cfg_i.bit_timeout) begin
        phase_d = PH_DONE;
        run_d   = 1'b0;
        code_d  = shift_ext[CodeW-1:0];
        valid_d = 1'b1;
        en_d    = 1'b0;
      end
    end

    // IR edge
    if (ir_fall_i && en_d) begin
      case (phase_d)
        PH_IDLE: begin
          phase_d = PH_START;
          shift_d = '0;
          timer_d = 16'd0;
          run_d   = 1'b1;
        end
        PH_START: begin
          if (timer_d > cfg_i.start_min) begin
            phase_d = PH_DATA;
            timer_d = 16'd0;
            run_d   = 1'b1;
          end else begin
            phase_d = PH_IDLE;
            run_d   = 1'b0;
          end
        end
        PH_DATA: begin
          shift_d = {shift_q[CODE_BITS-2:0], (timer_d > cfg_i.one_threshold)};
          timer_d = 16'd0;
          run_d   = 1'b1;
        end
        default: phase_d = phase_d;
      endcase
    end

    // slow prescaler and hold-off release
    pre_d = pre_q + 16'd1;
    if (pre_d >= cfg_i.slow_period) begin
      pre_d     = 16'd0;
      slow_tick = 1'b1;
    end
    if (slow_tick && !en_d) begin
      hold_d = hold_q + 3'd1;
      if (hold_d >= cfg_i.holdoff) begin
        en_d    = 1'b1;
        hold_d  = 3'd0;
        phase_d = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= 16'd0;
      run_q   <= 1'b0;
      shift_q <= '0;
      code_q  <= '0;
      valid_q <= 1'b0;
      en_q    <= 1'b1;
      hold_q  <= 3'd0;
      pre_q   <= 16'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      run_q   <= run_d;
      shift_q <= shift_d;
      code_q  <= code_d;
      valid_q <= valid_d;
      en_q    <= en_d;
      hold_q  <= hold_d;
      pre_q   <= pre_d;
    end
  end

  assign res_o.phase     = phase_d;
  assign res_o.valid     = valid_d;
  assign res_o.code      = code_d;
  assign res_o.slow_tick = slow_tick;

  // timer only runs inside a frame
  `IRPD_ASSERT_NOW(a_run_in_frame, run_q, (phase_q == PH_START || phase_q == PH_DATA))
  // edges are masked only while a latched frame is held
  `IRPD_ASSERT_NOW(a_mask_when_done, !en_q, phase_q == PH_DONE)
  // hold-off count only moves while edges are masked
  `IRPD_ASSERT_NOW(a_hold_masked, hold_q != 3'd0, !en_q)
  // once a code is latched it stays valid
  `IRPD_ASSERT_NEXT(a_valid_sticky, valid_q, valid_q)

endmodule

[rtl/ir_pd_select.sv]
// ---------------------------------------------------------------------------
// IR pulse-distance decoder byte selector
// Debounced button steps the shown byte; its nibbles map to segment codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ir_pd_select (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         button_fall_i,
  input  logic                         slow_tick_i,
  input  logic [2:0]                   debounce_i,
  input  logic [ir_pd_pkg::CodeW-1:0]  code_i,
  output logic [1:0]                   byte_idx_o,
  output logic [7:0]                   seg_high_o,
  output logic [7:0]                   seg_low_o
);
  import ir_pd_pkg::*;

  logic [2:0] deb_q, deb_d;
  logic [1:0] idx_q, idx_d;
  logic [7:0] byte_val;

  // debounce counter and byte index
  always_comb begin
    deb_d = deb_q;
    idx_d = idx_q;
    if (slow_tick_i && deb_q != 3'd7) begin
      deb_d = deb_q + 3'd1;
    end
    if (button_fall_i && deb_d >= debounce_i) begin
      idx_d = idx_q + 2'd1;
      deb_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= 3'd0;
      idx_q <= 2'd0;
    end else if (step_i) begin
      deb_q <= deb_d;
      idx_q <= idx_d;
    end
  end

  // byte 0 is the most significant
  always_comb begin
    case (idx_d)
      2'd0:    byte_val = code_i[31:24];
      2'd1:    byte_val = code_i[23:16];
      2'd2:    byte_val = code_i[15:8];
      default: byte_val = code_i[7:0];
    endcase
  end

  assign byte_idx_o = idx_d;
  assign seg_high_o = seg_lut(byte_val[7:4]);
  assign seg_low_o  = seg_lut(byte_val[3:0]);

endmodule

[rtl/ir_pulse_distance_decoder.sv]
// ---------------------------------------------------------------------------
// IR pulse-distance remote decoder
// Input word is one microsecond tick; output word is the display status.
// ---------------------------------------------------------------------------
// Each accepted input word produces exactly one output word. Words are taken
// one per clock unless the output side stalls; a word is latched into an
// input register, processed in a single pass through the frame engine and
// byte selector, and its result is registered; the registered result is
// taken when the output is not stalled. The output register lets a new word
// enter while a finished result waits, and the input register holds a word
// while the output side stalls. Configuration writes take effect on the next
// clock and are meant to be made while no word is in flight.
`timescale 1ns / 1ps

module ir_pulse_distance_decoder #(
  parameter int unsigned CODE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [ir_pd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ir_pd_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                ir_fall_i,
  input  logic                                button_fall_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                code_valid_o,
  output logic [ir_pd_pkg::CodeW-1:0]         code_word_o,
  output logic [1:0]                          byte_shown_o,
  output logic [7:0]                          seg_high_o,
  output logic [7:0]                          seg_low_o,
  output logic [1:0]                          decode_phase_o
);
  import ir_pd_pkg::*;

  cfg_t       cfg;
  frame_res_t frame_res;

  logic s1_valid_q, s1_valid_d;
  logic s1_ir_q, s1_btn_q;
  logic accept, advance, step;

  logic [1:0] byte_idx;
  logic [7:0] seg_high, seg_low;

  logic             out_valid_q;
  logic             code_valid_q;
  logic [CodeW-1:0] code_word_q;
  logic [1:0]       byte_shown_q;
  logic [7:0]       seg_high_q, seg_low_q;
  phase_e           phase_q;

  // handshake: step the engine whenever a word is held and the result register can take it
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ir_q  <= ir_fall_i;
      s1_btn_q <= button_fall_i;
    end
  end

  ir_pd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ir_pd_frame #(
    .CODE_BITS (CODE_BITS)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .ir_fall_i (s1_ir_q),
    .cfg_i     (cfg),
    .res_o     (frame_res)
  );

  ir_pd_select u_select (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .button_fall_i (s1_btn_q),
    .slow_tick_i   (frame_res.slow_tick),
    .debounce_i    (cfg.debounce),
    .code_i        (frame_res.code),
    .byte_idx_o    (byte_idx),
    .seg_high_o    (seg_high),
    .seg_low_o     (seg_low)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      code_valid_q <= frame_res.valid;
      code_word_q  <= frame_res.code;
      byte_shown_q <= byte_idx;
      seg_high_q   <= seg_high;
      seg_low_q    <= seg_low;
      phase_q      <= frame_res.phase;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_valid_o   = code_valid_q;
  assign code_word_o    = code_word_q;
  assign byte_shown_o   = byte_shown_q;
  assign seg_high_o     = seg_high_q;
  assign seg_low_o      = seg_low_q;
  assign decode_phase_o = phase_q;

endmodule

[bench/ir_pulse_distance_decoder_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IR pulse-distance decoder testbench
// Sends microsecond ticks carrying IR and button edges. Each display word that
// comes back is checked against a tick-level predictor of the decoder. A short
// directed table runs first. Random frames follow under several register
// settings. Both handshake sides idle and stall at random.
// ---------------------------------------------------------------------------

module ir_pulse_distance_decoder_tb;
  import ir_pd_pkg::*;

  localparam int unsigned ShiftW = 32;
  localparam int unsigned DirLen = 30;
  localparam int unsigned JamAt  = 600;
  localparam int unsigned JamLen = 80;

  // active-low digit patterns, 0..F
  localparam logic [7:0] SegPat [16] = '{
    8'hC0, 8'hF3, 8'hA4, 8'hA1, 8'h93, 8'h89, 8'h88, 8'hE3,
    8'h80, 8'h81, 8'h82, 8'h98, 8'hCC, 8'hB0, 8'h8C, 8'h8E
  };

  // one display word as seen on the output side
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
    logic [1:0]       sel;
    logic [7:0]       seg_hi;
    logic [7:0]       seg_lo;
    phase_e           phase;
  } disp_t;

  // decoder state mirrored by the predictor
  typedef struct packed {
    phase_e            phase;
    logic [15:0]       gap;
    logic              running;
    logic [ShiftW-1:0] shreg;
    logic [CodeW-1:0]  code;
    logic              valid;
    logic              edges_on;
    logic [2:0]        hold_cnt;
    logic [2:0]        deb_cnt;
    logic [1:0]        sel;
    logic [15:0]       prescale;
  } dec_state_t;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    cfg_idx_e    idx;
    logic [15:0] val;
    logic        ir;
    logic        btn;
    logic        lit;
    disp_t       want;
  } dir_row_t;

  localparam disp_t ResIdle  = '{1'b0, 32'h0, 2'd0, 8'hC0, 8'hC0, PH_IDLE};
  localparam disp_t ResStart = '{1'b0, 32'h0, 2'd0, 8'hC0, 8'hC0, PH_START};

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic              ir_fall_i     = 1'b0;
  logic              button_fall_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic              code_valid_o;
  logic [CodeW-1:0]  code_word_o;
  logic [1:0]        byte_shown_o;
  logic [7:0]        seg_high_o;
  logic [7:0]        seg_low_o;
  logic [1:0]        decode_phase_o;

  cfg_t        cur_cfg;
  dec_state_t  dec;
  disp_t       disp_q [$];
  dir_row_t    dir_tab [DirLen];
  int unsigned sent_cnt = 0;
  int unsigned rcv_cnt  = 0;
  int unsigned err_cnt  = 0;
  int unsigned jam_left = 0;
  bit          jam_done = 1'b0;

  ir_pulse_distance_decoder #(
    .CODE_BITS(ShiftW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .ir_fall_i     (ir_fall_i),
    .button_fall_i (button_fall_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_valid_o  (code_valid_o),
    .code_word_o   (code_word_o),
    .byte_shown_o  (byte_shown_o),
    .seg_high_o    (seg_high_o),
    .seg_low_o     (seg_low_o),
    .decode_phase_o(decode_phase_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // one microsecond of decoder behavior; returns the display word
  function automatic disp_t decode_tick(input bit ir, input bit btn);
    disp_t      r;
    logic [7:0] shown;
    // gap timer and timeouts
    if (dec.running) begin
      if (dec.gap != 16'hFFFF) dec.gap = dec.gap + 16'd1;
      if (dec.phase == PH_START && dec.gap >= cur_cfg.start_timeout) begin
        dec.phase   = PH_IDLE;
        dec.running = 1'b0;
      end else if (dec.phase == PH_DATA && dec.gap >= cur_cfg.bit_timeout) begin
        dec.phase    = PH_DONE;
        dec.running  = 1'b0;
        dec.code     = dec.shreg[CodeW-1:0];
        dec.valid    = 1'b1;
        dec.edges_on = 1'b0;
      end
    end
    // IR edge
    if (ir && dec.edges_on) begin
      case (dec.phase)
        PH_IDLE: begin
          dec.phase   = PH_START;
          dec.shreg   = '0;
          dec.gap     = '0;
          dec.running = 1'b1;
        end
        PH_START: begin
          if (dec.gap > cur_cfg.start_min) begin
            dec.phase   = PH_DATA;
            dec.gap     = '0;
            dec.running = 1'b1;
          end else begin
            dec.phase   = PH_IDLE;
            dec.running = 1'b0;
          end
        end
        PH_DATA: begin
          dec.shreg   = {dec.shreg[ShiftW-2:0], dec.gap > cur_cfg.one_threshold};
          dec.gap     = '0;
          dec.running = 1'b1;
        end
        default: ;
      endcase
    end
    // slow tick: holdoff and debounce
    dec.prescale = dec.prescale + 16'd1;
    if (dec.prescale >= cur_cfg.slow_period) begin
      dec.prescale = '0;
      if (!dec.edges_on) begin
        dec.hold_cnt = dec.hold_cnt + 3'd1;
        if (dec.hold_cnt >= cur_cfg.holdoff) begin
          dec.edges_on = 1'b1;
          dec.hold_cnt = '0;
          dec.phase    = PH_IDLE;
        end
      end
      if (dec.deb_cnt != 3'd7) dec.deb_cnt = dec.deb_cnt + 3'd1;
    end
    // byte select button
    if (btn && dec.deb_cnt >= cur_cfg.debounce) begin
      dec.sel     = dec.sel + 2'd1;
      dec.deb_cnt = '0;
    end
    shown    = dec.code[8 * (3 - int'(dec.sel)) +: 8];
    r.valid  = dec.valid;
    r.code   = dec.code;
    r.sel    = dec.sel;
    r.seg_hi = SegPat[shown[7:4]];
    r.seg_lo = SegPat[shown[3:0]];
    r.phase  = dec.phase;
    return r;
  endfunction

  function automatic dir_row_t tick_row(input bit ir, input bit btn);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_TICK;
    r.ir   = ir;
    r.btn  = btn;
    return r;
  endfunction

  function automatic dir_row_t lit_row(input bit ir, input bit btn, input disp_t want);
    dir_row_t r;
    r      = tick_row(ir, btn);
    r.lit  = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic dir_row_t reg_row(input cfg_idx_e idx, input logic [15:0] val);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic bit poke_btn();
    return $urandom_range(99) < 6;
  endfunction

  // small timings so that whole frames fit in a few hundred ticks
  function automatic cfg_t pick_cfg();
    cfg_t c;
    c.one_threshold = 16'($urandom_range(1, 3));
    c.bit_timeout   = c.one_threshold + 16'($urandom_range(2, 5));
    c.start_min     = 16'($urandom_range(0, 6));
    c.start_timeout = c.start_min + 16'($urandom_range(2, 10));
    c.slow_period   = 16'($urandom_range(0, 5));
    c.holdoff       = 3'($urandom_range(0, 7));
    c.debounce      = 3'($urandom_range(0, 7));
    return c;
  endfunction

  // offer one tick word, wait for it to be taken, queue its prediction
  task automatic send_tick(input bit ir, input bit btn,
                           input bit use_lit = 1'b0, input disp_t lit = '0);
    disp_t pred;
    while (!(sent_cnt >= 200 && sent_cnt < 450) && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    ir_fall_i     <= ir;
    button_fall_i <= btn;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = decode_tick(ir, btn);
    disp_q.push_back(use_lit ? lit : pred);
    sent_cnt++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (disp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_START_TIMEOUT: cur_cfg.start_timeout = val;
      CFG_START_MIN:     cur_cfg.start_min     = val;
      CFG_BIT_TIMEOUT:   cur_cfg.bit_timeout   = val;
      CFG_ONE_THRESHOLD: cur_cfg.one_threshold = val;
      CFG_SLOW_PERIOD:   cur_cfg.slow_period   = val;
      CFG_HOLDOFF:       cur_cfg.holdoff       = val[2:0];
      CFG_DEBOUNCE:      cur_cfg.debounce      = val[2:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(input cfg_t c);
    write_reg(CFG_START_TIMEOUT, c.start_timeout);
    write_reg(CFG_START_MIN, c.start_min);
    write_reg(CFG_BIT_TIMEOUT, c.bit_timeout);
    write_reg(CFG_ONE_THRESHOLD, c.one_threshold);
    write_reg(CFG_SLOW_PERIOD, c.slow_period);
    write_reg(CFG_HOLDOFF, {13'd0, c.holdoff});
    write_reg(CFG_DEBOUNCE, {13'd0, c.debounce});
  endtask

  // g-1 quiet ticks, then an IR edge
  task automatic gap_then_edge(input int unsigned g);
    repeat (g - 1) send_tick(1'b0, poke_btn());
    send_tick(1'b1, poke_btn());
  endtask

  // one remote frame with random payload, sometimes malformed, then silence
  task automatic send_frame();
    int unsigned thr, bto, smin, sto, g, nbits, pick, rest;
    thr  = int'(cur_cfg.one_threshold);
    bto  = int'(cur_cfg.bit_timeout);
    smin = int'(cur_cfg.start_min);
    sto  = int'(cur_cfg.start_timeout);
    pick = $urandom_range(99);
    nbits = (pick < 50) ? 32 : (pick < 75) ? $urandom_range(1, 31) : $urandom_range(33, 40);
    gap_then_edge(1);
    if (sto > smin + 1 && $urandom_range(99) < 85) g = $urandom_range(smin + 1, sto - 1);
    else g = $urandom_range(1, sto + 3);
    gap_then_edge(g);
    for (int i = 0; i < int'(nbits); i++) begin
      pick = $urandom_range(99);
      if (pick < 3) g = bto + $urandom_range(0, 2);       // gap ends the frame early
      else if (pick < 50 || bto < thr + 2) g = $urandom_range(1, (thr == 0) ? 1 : thr);
      else g = $urandom_range(thr + 1, (bto - 1 < thr + 3) ? bto - 1 : thr + 3);
      gap_then_edge(g);
    end
    // bit timeout plus holdoff, with stray edges that must be ignored
    rest = bto + (int'(cur_cfg.slow_period) + 1) * (int'(cur_cfg.holdoff) + 1)
           + $urandom_range(0, 4);
    repeat (rest) send_tick($urandom_range(99) < 4, poke_btn());
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      err_cnt++;
    end
  endtask

  // output monitor
  always @(posedge clk_i) begin
    disp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rcv_cnt <= rcv_cnt + 1;
      if (disp_q.size() == 0) begin
        $display("%0t: unexpected output word, expected none, got code %h phase %0d",
                 $time, code_word_o, decode_phase_o);
        err_cnt++;
      end else begin
        want = disp_q.pop_front();
        check_field("code_valid", 32'(want.valid), 32'(code_valid_o));
        check_field("code_word", want.code, code_word_o);
        check_field("byte_shown", 32'(want.sel), 32'(byte_shown_o));
        check_field("seg_high", 32'(want.seg_hi), 32'(seg_high_o));
        check_field("seg_low", 32'(want.seg_lo), 32'(seg_low_o));
        check_field("decode_phase", 32'(want.phase), 32'(decode_phase_o));
      end
    end
  end

  // receiver stall: random, a calm window, and one long jam
  always @(posedge clk_i) begin
    if (jam_left != 0) begin
      out_stall_i <= 1'b1;
      jam_left    <= jam_left - 1;
    end else if (!jam_done && rcv_cnt >= JamAt) begin
      out_stall_i <= 1'b1;
      jam_left    <= JamLen;
      jam_done    <= 1'b1;
    end else if (rcv_cnt >= 200 && rcv_cnt < 450) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 21);
    end
  end

  initial begin
    int unsigned base;
    cur_cfg = '{RstStartTimeout, RstStartMin, RstBitTimeout, RstOneThreshold,
                RstSlowPeriod, RstHoldoff, RstDebounce};
    dec          = '0;
    dec.phase    = PH_IDLE;
    dec.edges_on = 1'b1;
    dir_tab = '{
      lit_row(1'b0, 1'b0, ResIdle),            // state right after reset
      lit_row(1'b0, 1'b1, ResIdle),            // press ignored, not debounced yet
      lit_row(1'b1, 1'b0, ResStart),
      lit_row(1'b1, 1'b0, ResIdle),            // start gap too short
      reg_row(CFG_UNUSED, 16'hFFFF),           // no such register
      reg_row(CFG_START_TIMEOUT, 16'h0000),
      tick_row(1'b1, 1'b0),
      tick_row(1'b0, 1'b0),                    // zero start timeout fires at once
      reg_row(CFG_START_TIMEOUT, 16'hFFFF),
      reg_row(CFG_START_MIN, 16'h0000),
      reg_row(CFG_BIT_TIMEOUT, 16'h0000),
      reg_row(CFG_ONE_THRESHOLD, 16'h0001),
      reg_row(CFG_SLOW_PERIOD, 16'h0000),      // slow tick every microsecond
      reg_row(CFG_HOLDOFF, 16'hFFF8),          // upper bits dropped, holdoff zero
      reg_row(CFG_DEBOUNCE, 16'h0000),
      tick_row(1'b1, 1'b0),
      tick_row(1'b1, 1'b0),
      tick_row(1'b0, 1'b0),                    // empty frame latched, edges back
      tick_row(1'b0, 1'b1),                    // zero debounce takes every press
      reg_row(CFG_BIT_TIMEOUT, 16'h0003),
      tick_row(1'b1, 1'b1),
      tick_row(1'b1, 1'b0),
      tick_row(1'b1, 1'b0),                    // short gap, bit 0
      tick_row(1'b0, 1'b0),
      tick_row(1'b1, 1'b0),                    // long gap, bit 1
      tick_row(1'b0, 1'b1),
      tick_row(1'b0, 1'b0),
      tick_row(1'b0, 1'b0),                    // bit timeout latches the code
      tick_row(1'b0, 1'b1),
      tick_row(1'b0, 1'b1)                     // byte select wraps around
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) write_reg(dir_tab[i].idx, dir_tab[i].val);
      else send_tick(dir_tab[i].ir, dir_tab[i].btn, dir_tab[i].lit, dir_tab[i].want);
    end

    // random frames under several settings; each reload drains the block
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: load_cfg('{16'd30, 16'd4, 16'd12, 16'd3, 16'd4, 3'd2, 3'd1});
        3: load_cfg('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 3'd7});
        4: load_cfg('{16'd16, 16'd3, 16'd9, 16'd2, 16'd1, 3'd7, 3'd7});
        default: load_cfg(pick_cfg());
      endcase
      base = sent_cnt;
      while (sent_cnt - base < ((s == 3) ? 120 : 200)) begin
        if (s != 3 && $urandom_range(99) < 85) send_frame();
        else repeat (20) send_tick($urandom_range(99) < 25, $urandom_range(99) < 15);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && disp_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
